// ===== rtl/iomft_pkg.sv =====
package iomft_pkg;

  localparam int ADDR_W      = 32;
  localparam int SLOT_W      = 10;
  localparam int USED_W      = 11;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_FINISH
  } back_state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic              blocked;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [USED_W-1:0] used_entries;
  } result_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] cmp;
  } cmd_t;

  // one table entry as held in RAM; live marks a slot not freed
  typedef struct packed {
    logic              live;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] cmp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // 0xFF in every octet where the pattern octet is nonzero
  function automatic logic [ADDR_W-1:0] octet_mask(input logic [ADDR_W-1:0] pattern);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int k = 0; k < ADDR_W / 8; k++) begin
      if (pattern[8*k +: 8] != 8'd0) begin
        m[8*k +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/ipv4_octet_mask_filter_table_core.sv =====
// IPv4 octet-mask filter table.
// Input channel (item, item_valid, item_stall): one word per operation:
// check an address, add a filter pattern, remove a pattern, clear the table.
// A zero octet in a pattern is a wildcard. Output channel (result,
// result_valid, result_stall): exactly one result word per input word, in order.
// Config channel (cfg_data, cfg_valid, cfg_ready): writes ban_mode; 1 blocks
// matching addresses, 0 admits only matching ones. cfg_ready is always high.
// The back end reads the table RAM one entry per cycle over the N entries in use
// and stops at the first hit; clear skips the scan. The back end takes a new
// word only once it is done with the last one.
// A two-word queue lets new words be taken while the back end is scanning.
// Reset empties the table (fill count to 0, no RAM sweep) and sets ban_mode.
// While result_stall is high the result is held and the back end waits once
// the next result is ready; the queue then fills and item_stall rises.
module ipv4_octet_mask_filter_table_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  iomft_pkg::item_t   item,
  input  logic               item_valid,
  output logic               item_stall,
  output iomft_pkg::result_t result,
  output logic               result_valid,
  input  logic               result_stall,
  input  logic               cfg_data,
  input  logic               cfg_valid,
  output logic               cfg_ready
);

  import iomft_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic ban_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ban_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      ban_mode <= cfg_data;
    end
  end

  iomft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop)
  );

  iomft_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .ban_mode     (ban_mode),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

`ifndef SYNTH
  a_full_at_depth: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == STATUS_FULL)
      |-> (result.used_entries == USED_W'(TABLE_DEPTH)) && (result.slot == '0))
    else $error("table full reported below capacity");

  a_not_found_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == STATUS_NOT_FOUND)
      |-> (result.slot == '0) && !result.blocked)
    else $error("not-found result carries a slot or verdict");

  a_blocked_only_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.blocked |-> (result.status == STATUS_DONE))
    else $error("blocked set on a failed operation");
`endif

endmodule

// ===== rtl/iomft_ram.sv =====
module iomft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/iomft_front.sv =====
module iomft_front (
  input  logic             clk,
  input  logic             rst,
  input  iomft_pkg::item_t item,
  input  logic             item_valid,
  output logic             item_stall,
  output iomft_pkg::cmd_t  cmd,
  output logic             cmd_valid,
  input  logic             cmd_pop
);

  import iomft_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  cmd_t              classified;

  always_comb begin
    classified.op      = op_e'(item.operation);
    classified.address = item.address;
    classified.mask    = octet_mask(item.address);
    classified.cmp     = item.address & octet_mask(item.address);
  end

  assign item_stall = (fill == FILL_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign cmd_valid  = (fill != '0);
  assign cmd        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (cmd_pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !cmd_pop) begin
        fill <= FILL_W'(fill + 1'b1);
      end else if (!push && cmd_pop) begin
        fill <= FILL_W'(fill - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/iomft_back.sv =====
module iomft_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  iomft_pkg::cmd_t    cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic               ban_mode,
  output iomft_pkg::result_t result,
  output logic               result_valid,
  input  logic               result_stall
);

  import iomft_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  back_state_e       state, state_next;
  cmd_t              cur, cur_next;
  logic [CNT_W-1:0]  scan_idx, scan_idx_next;
  logic [IDX_W-1:0]  eval_idx, eval_idx_next;
  logic              rd_pend, rd_pend_next;
  logic              found, found_next;
  logic [IDX_W-1:0]  found_idx, found_idx_next;
  logic [CNT_W-1:0]  count, count_next;
  result_t           result_next;
  logic              result_valid_next;

  logic [ENTRY_W-1:0] rdata;
  entry_t            rentry;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wentry;
  logic              cond;
  logic              hit;
  logic              more;
  logic              result_free;
  logic              can_append;

  iomft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign rentry = entry_t'(rdata);

  always_comb begin
    case (cur.op)
      OP_CHECK:  cond = rentry.live && ((cur.address & rentry.mask) == rentry.cmp);
      OP_ADD:    cond = !rentry.live;
      OP_REMOVE: cond = rentry.live && (rentry.mask == cur.mask) && (rentry.cmp == cur.cmp);
      default:   cond = 1'b0;
    endcase
  end

  assign hit         = rd_pend && cond;
  assign more        = (scan_idx < count);
  assign result_free = !result_valid || !result_stall;
  assign can_append  = (count < DEPTH_CNT);

  always_comb begin
    state_next        = state;
    cur_next          = cur;
    scan_idx_next     = scan_idx;
    eval_idx_next     = eval_idx;
    rd_pend_next      = 1'b0;
    found_next        = found;
    found_idx_next    = found_idx;
    count_next        = count;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    cmd_pop           = 1'b0;
    we                = 1'b0;
    waddr             = found_idx;
    wentry.live       = (cur.op == OP_ADD);
    wentry.mask       = cur.mask;
    wentry.cmp        = cur.cmp;

    unique case (state)
      BS_IDLE: begin
        scan_idx_next = '0;
        found_next    = 1'b0;
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cur_next   = cmd;
          state_next = (cmd.op == OP_CLEAR) ? BS_FINISH : BS_SCAN;
        end
      end
      BS_SCAN: begin
        // a read is judged in the cycle after it is issued; a spare read after a hit is dropped
        if (hit) begin
          found_next     = 1'b1;
          found_idx_next = eval_idx;
          state_next     = BS_FINISH;
        end else if (more) begin
          rd_pend_next  = 1'b1;
          eval_idx_next = scan_idx[IDX_W-1:0];
          scan_idx_next = CNT_W'(scan_idx + 1'b1);
        end else if (!rd_pend) begin
          found_next = 1'b0;
          state_next = BS_FINISH;
        end
      end
      BS_FINISH: begin
        if (result_free) begin
          result_next.blocked = 1'b0;
          result_next.status  = STATUS_DONE;
          result_next.slot    = '0;
          unique case (cur.op)
            OP_CHECK: begin
              result_next.blocked = found ? ban_mode : !ban_mode;
              if (found) begin
                result_next.slot = SLOT_W'(found_idx);
              end
            end
            OP_ADD: begin
              if (found) begin
                we               = 1'b1;
                result_next.slot = SLOT_W'(found_idx);
              end else if (can_append) begin
                we               = 1'b1;
                waddr            = count[IDX_W-1:0];
                count_next       = CNT_W'(count + 1'b1);
                result_next.slot = SLOT_W'(count[IDX_W-1:0]);
              end else begin
                result_next.status = STATUS_FULL;
              end
            end
            OP_REMOVE: begin
              if (found) begin
                we               = 1'b1;
                result_next.slot = SLOT_W'(found_idx);
              end else begin
                result_next.status = STATUS_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
          result_next.used_entries = USED_W'(count_next);
          result_valid_next        = 1'b1;
          state_next               = BS_IDLE;
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BS_IDLE;
      rd_pend      <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rd_pend      <= rd_pend_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    scan_idx  <= scan_idx_next;
    eval_idx  <= eval_idx_next;
    found     <= found_next;
    found_idx <= found_idx_next;
    result    <= result_next;
  end

endmodule
